// File: design/ecs_pkg.sv
`timescale 1ns / 1ps
package ecs_pkg;

    // default number of event slots
    localparam int SLOT_COUNT_DEF = 6;

    localparam int COUNT_W = 31;
    localparam int SLOT_W  = 3;

    // configuration register indexes
    localparam logic CFG_RELOAD_SLOT   = 1'b0;
    localparam logic CFG_RELOAD_PERIOD = 1'b1;

    typedef enum logic [1:0] {
        FN_ARM     = 2'd0,
        FN_CANCEL  = 2'd1,
        FN_ADVANCE = 2'd2,
        FN_QUERY   = 2'd3
    } t_func_e;

    typedef enum logic [1:0] {
        RK_FIRED = 2'd0,
        RK_NEXT  = 2'd1,
        RK_NONE  = 2'd2
    } t_kind_e;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } t_state_e;

    // one result item on its way to the output register
    typedef struct packed {
        t_kind_e             kind;
        logic [SLOT_W-1:0]   slot;
        logic [COUNT_W-1:0]  dur;
        logic                last;
    } t_res;

endpackage

// File: design/event_countdown_scheduler_top.sv
`timescale 1ns / 1ps
// channel   direction  handshake             payload
// s         in         i_s_tvalid/o_s_tready tuser func, tdata slot+amount
// m         out        o_m_tvalid/i_m_tready tuser kind, tdata slot+duration, tlast
// cfg       in         i_cfg_we              i_cfg_addr, i_cfg_wdata
//
// arm and cancel are done in the idle state; advance and query walk through the count RAM
// one slot per cycle while a stalled output does not hold the scan.
// reset is synchronous active low; it idles all slots, the count RAM needs no clearing.
// a stalled output holds the scan while a second fired result waits to be pushed.
module event_countdown_scheduler_top import ecs_pkg::*; #(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // slot[2:0], amount[33:3], zero pad
    input  logic [1:0]  i_s_tuser,   // func[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // fired_slot[2:0], next_duration[33:3], zero pad
    output logic [1:0]  o_m_tuser,   // result_kind[1:0]
    output logic        o_m_tlast,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [30:0] i_cfg_wdata
);

    localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    logic               we, re, push, can_push;
    logic [AW-1:0]      waddr, raddr;
    logic [COUNT_W-1:0] wdata, rdata;
    t_res               res;

    // sequencer and slot flags
    ecs_ctrl #(.SLOT_COUNT(SLOT_COUNT)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_func      (t_func_e'(i_s_tuser)),
        .i_slot      (i_s_tdata[2:0]),
        .i_amount    (i_s_tdata[33:3]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_re        (re),
        .o_raddr     (raddr),
        .i_rdata     (rdata),
        .o_push      (push),
        .o_res       (res),
        .i_can_push  (can_push)
    );

    // remaining counts
    ecs_ram #(.WIDTH(COUNT_W), .DEPTH(SLOT_COUNT)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // output register
    ecs_outbuf u_outbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_res      (res),
        .o_can_push (can_push),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

// File: design/ecs_ram.sv
`timescale 1ns / 1ps
module ecs_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 6,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/ecs_outbuf.sv
`timescale 1ns / 1ps
module ecs_outbuf import ecs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_res        i_res,
    output logic        o_can_push,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,
    output logic [1:0]  o_m_tuser,
    output logic        o_m_tlast
);

    logic r_vld;
    t_res r_res;

    assign o_can_push = !r_vld || i_m_tready;

    // valid flag of the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_can_push) begin
            r_vld <= i_push;
        end
    end

    // payload, loaded only on a push
    always_ff @(posedge i_clk) begin
        if (o_can_push && i_push) begin
            r_res <= i_res;
        end
    end

    assign o_m_tvalid = r_vld;
    assign o_m_tdata  = {6'd0, r_res.dur, r_res.slot};
    assign o_m_tuser  = r_res.kind;
    assign o_m_tlast  = r_res.last;

endmodule

// File: design/ecs_ctrl.sv
`timescale 1ns / 1ps
module ecs_ctrl import ecs_pkg::*; #(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input item
    input  logic               i_valid,
    output logic               o_ready,
    input  t_func_e            i_func,
    input  logic [SLOT_W-1:0]  i_slot,
    input  logic [COUNT_W-1:0] i_amount,
    // configuration
    input  logic               i_cfg_we,
    input  logic               i_cfg_addr,
    input  logic [COUNT_W-1:0] i_cfg_wdata,
    // count memory
    output logic               o_we,
    output logic [AW-1:0]      o_waddr,
    output logic [COUNT_W-1:0] o_wdata,
    output logic               o_re,
    output logic [AW-1:0]      o_raddr,
    input  logic [COUNT_W-1:0] i_rdata,
    // result push
    output logic               o_push,
    output t_res               o_res,
    input  logic               i_can_push
);

    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam logic [CW-1:0] LAST_IDX = CW'(SLOT_COUNT);

    t_state_e            r_state, n_state;
    t_func_e             r_func, n_func;
    logic [COUNT_W-1:0]  r_amount, n_amount;
    logic [COUNT_W-1:0]  r_best, n_best;
    logic [CW-1:0]       r_rd_idx, n_rd_idx;
    logic                r_ev_vld, n_ev_vld;
    logic [AW-1:0]       r_ev_idx, n_ev_idx;
    logic [SLOT_COUNT-1:0] r_armed, n_armed;
    logic                r_pend_vld, n_pend_vld;
    logic [AW-1:0]       r_pend_slot, n_pend_slot;
    logic [SLOT_W-1:0]   r_reload_slot;
    logic [COUNT_W-1:0]  r_reload_period;

    logic in_range;
    logic ev_armed;
    logic fire;
    logic stall;
    logic issue;
    logic reload_hit;

    assign in_range   = ({1'b0, i_slot} < 4'(SLOT_COUNT));
    assign ev_armed   = r_ev_vld && r_armed[r_ev_idx];
    assign fire       = ev_armed && (r_func == FN_ADVANCE) && (i_rdata <= r_amount);
    assign stall      = fire && r_pend_vld && !i_can_push;
    assign issue      = (r_rd_idx < LAST_IDX) && !stall;
    assign reload_hit = (SLOT_W'(r_ev_idx) == r_reload_slot) && (r_reload_period != '0);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reload_slot   <= '0;
            r_reload_period <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_RELOAD_SLOT:   r_reload_slot   <= i_cfg_wdata[SLOT_W-1:0];
                CFG_RELOAD_PERIOD: r_reload_period <= i_cfg_wdata;
                default:           r_reload_slot   <= r_reload_slot;
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_ev_vld   <= 1'b0;
            r_armed    <= '0;
            r_pend_vld <= 1'b0;
            r_rd_idx   <= '0;
        end else begin
            r_state    <= n_state;
            r_ev_vld   <= n_ev_vld;
            r_armed    <= n_armed;
            r_pend_vld <= n_pend_vld;
            r_rd_idx   <= n_rd_idx;
        end
    end

    // item payload and scan registers
    always_ff @(posedge i_clk) begin
        r_func      <= n_func;
        r_amount    <= n_amount;
        r_best      <= n_best;
        r_ev_idx    <= n_ev_idx;
        r_pend_slot <= n_pend_slot;
    end

    // sequencer: idle, slot scan with read-modify-write, final result
    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_amount    = r_amount;
        n_best      = r_best;
        n_rd_idx    = r_rd_idx;
        n_ev_vld    = r_ev_vld;
        n_ev_idx    = r_ev_idx;
        n_armed     = r_armed;
        n_pend_vld  = r_pend_vld;
        n_pend_slot = r_pend_slot;
        o_ready     = 1'b0;
        o_we        = 1'b0;
        o_waddr     = r_ev_idx;
        o_wdata     = '0;
        o_re        = 1'b0;
        o_raddr     = r_rd_idx[AW-1:0];
        o_push      = 1'b0;
        o_res.kind  = RK_FIRED;
        o_res.slot  = SLOT_W'(r_pend_slot);
        o_res.dur   = '0;
        o_res.last  = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    unique case (i_func)
                        FN_ARM: begin
                            if (in_range) begin
                                o_we    = 1'b1;
                                o_waddr = i_slot[AW-1:0];
                                o_wdata = i_amount;
                                n_armed[i_slot[AW-1:0]] = 1'b1;
                            end
                        end
                        FN_CANCEL: begin
                            if (in_range) begin
                                n_armed[i_slot[AW-1:0]] = 1'b0;
                            end
                        end
                        FN_ADVANCE, FN_QUERY: begin
                            n_func     = i_func;
                            n_amount   = i_amount;
                            n_best     = i_amount;
                            n_rd_idx   = '0;
                            n_ev_vld   = 1'b0;
                            n_pend_vld = 1'b0;
                            n_state    = ST_SCAN;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end

            ST_SCAN: begin
                if (!stall) begin
                    // next read issue
                    o_re     = issue;
                    n_ev_vld = issue;
                    n_ev_idx = r_rd_idx[AW-1:0];
                    if (issue) begin
                        n_rd_idx = r_rd_idx + CW'(1);
                    end
                    // evaluate the slot whose count has just been read
                    if (ev_armed) begin
                        if (r_func == FN_QUERY) begin
                            if (i_rdata < r_best) begin
                                n_best = i_rdata;
                            end
                        end else if (fire) begin
                            o_push      = r_pend_vld;
                            n_pend_vld  = 1'b1;
                            n_pend_slot = r_ev_idx;
                            if (reload_hit) begin
                                o_we    = 1'b1;
                                o_wdata = r_reload_period;
                            end else begin
                                n_armed[r_ev_idx] = 1'b0;
                            end
                        end else begin
                            o_we    = 1'b1;
                            o_wdata = i_rdata - r_amount;
                        end
                    end
                    if (!r_ev_vld && (r_rd_idx == LAST_IDX)) begin
                        n_state = ST_FIN;
                    end
                end
            end

            ST_FIN: begin
                o_res.last = 1'b1;
                if (r_func == FN_QUERY) begin
                    o_res.kind = RK_NEXT;
                    o_res.slot = '0;
                    o_res.dur  = r_best;
                end else if (!r_pend_vld) begin
                    o_res.kind = RK_NONE;
                    o_res.slot = '0;
                end
                if (i_can_push) begin
                    o_push  = 1'b1;
                    n_state = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// File: design/ecs_checker.sv
`timescale 1ns / 1ps
module ecs_checker import ecs_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [39:0] i_s_tdata,
    input logic [1:0]  i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [39:0] o_m_tdata,
    input logic [1:0]  o_m_tuser,
    input logic        o_m_tlast,
    input logic        i_cfg_we,
    input logic        i_cfg_addr,
    input logic [30:0] i_cfg_wdata
);

    // a waiting result item stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> o_m_tvalid)
        else $error("output item dropped while stalled");

    // advance and query occupy the block, no item taken right after
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready &&
         (i_s_tuser == FN_ADVANCE || i_s_tuser == FN_QUERY)) |=> !o_s_tready)
        else $error("item taken during a scan");

    // query answers and empty advances are single items
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == RK_NEXT || o_m_tuser == RK_NONE)) |-> o_m_tlast)
        else $error("single result without last");

    // only defined result kinds, with zero duration on fired and empty items
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != RK_NEXT) |->
        (o_m_tuser != 2'd3 && o_m_tdata[33:3] == '0))
        else $error("bad result kind or duration");

endmodule

bind event_countdown_scheduler_top ecs_checker u_ecs_checker (.*);

// File: dv/event_countdown_checker.sv
`timescale 1ns / 1ps
module event_countdown_checker import ecs_pkg::*; #(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [39:0] i_s_tdata,   // slot[2:0], amount[33:3], zero pad
    input  logic [1:0]  i_s_tuser,   // func[1:0]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [39:0] i_m_tdata,   // fired_slot[2:0], next_duration[33:3], zero pad
    input  logic [1:0]  i_m_tuser,   // result_kind[1:0]
    input  logic        i_m_tlast,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [30:0] i_cfg_wdata,
    output int          o_fail_count,
    output int          o_results_owed
);

    // shadow copy of the slot table and its registers
    logic [SLOT_W-1:0]  reload_slot;
    logic [COUNT_W-1:0] reload_period;
    logic               armed [SLOT_COUNT];
    logic [COUNT_W-1:0] count_left [SLOT_COUNT];

    // results still owed by the block, oldest first
    t_res owed_q [$];
    int   fails = 0;

    task automatic report_mismatch(string what, longint want, longint got);
        $display("%0t: mismatch on %s, expected %0d, got %0d", $time, what, want, got);
        fails++;
    endtask

    function automatic void owe_result(t_kind_e k, logic [SLOT_W-1:0] s,
                                       logic [COUNT_W-1:0] d, logic l);
        t_res r;
        r.kind = k;
        r.slot = s;
        r.dur  = d;
        r.last = l;
        owed_q.push_back(r);
    endfunction

    // work out what one accepted item does to the table and what it returns
    task automatic predict_item(t_func_e fn, logic [SLOT_W-1:0] sl,
                                logic [COUNT_W-1:0] amt);
        logic [COUNT_W-1:0] best;
        int                 n_fired;
        t_res               tail;
        case (fn)
            FN_ARM: begin
                if (sl < SLOT_COUNT) begin
                    armed[sl]      = 1'b1;
                    count_left[sl] = amt;
                end
            end
            FN_CANCEL: begin
                if (sl < SLOT_COUNT)
                    armed[sl] = 1'b0;
            end
            FN_QUERY: begin
                best = amt;
                for (int i = 0; i < SLOT_COUNT; i++)
                    if (armed[i] && count_left[i] < best)
                        best = count_left[i];
                owe_result(RK_NEXT, '0, best, 1'b1);
            end
            default: begin
                // advance: walk slots in order, the re-armed one is not touched again
                n_fired = 0;
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (armed[i]) begin
                        if (count_left[i] <= amt) begin
                            armed[i]      = 1'b0;
                            count_left[i] = '0;
                            owe_result(RK_FIRED, SLOT_W'(i), '0, 1'b0);
                            n_fired++;
                            if (i == reload_slot && reload_period != 0) begin
                                armed[i]      = 1'b1;
                                count_left[i] = reload_period;
                            end
                        end else begin
                            count_left[i] = count_left[i] - amt;
                        end
                    end
                end
                if (n_fired == 0) begin
                    owe_result(RK_NONE, '0, '0, 1'b1);
                end else begin
                    tail      = owed_q.pop_back();
                    tail.last = 1'b1;
                    owed_q.push_back(tail);
                end
            end
        endcase
    endtask

    // compare one accepted result with the oldest one owed
    task automatic check_result();
        t_res want;
        if (owed_q.size() == 0) begin
            report_mismatch("unexpected result kind", -1, i_m_tuser);
            return;
        end
        want = owed_q.pop_front();
        if (i_m_tuser != want.kind)
            report_mismatch("result_kind", want.kind, i_m_tuser);
        if (i_m_tdata[2:0] != want.slot)
            report_mismatch("fired_slot", want.slot, i_m_tdata[2:0]);
        if (i_m_tdata[33:3] != want.dur)
            report_mismatch("next_duration", want.dur, i_m_tdata[33:3]);
        if (i_m_tdata[39:34] != '0)
            report_mismatch("tdata pad", 0, i_m_tdata[39:34]);
        if (i_m_tlast != want.last)
            report_mismatch("last", want.last, i_m_tlast);
    endtask

    // sample all channels at the clock edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reload_slot   = '0;
            reload_period = '0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                armed[i]      = 1'b0;
                count_left[i] = '0;
            end
            owed_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_RELOAD_SLOT)
                    reload_slot = i_cfg_wdata[SLOT_W-1:0];
                else
                    reload_period = i_cfg_wdata;
            end
            if (i_m_tvalid && i_m_tready)
                check_result();
            if (i_s_tvalid && i_s_tready)
                predict_item(t_func_e'(i_s_tuser), i_s_tdata[2:0], i_s_tdata[33:3]);
        end
        o_results_owed <= owed_q.size();
        o_fail_count   <= fails;
    end

endmodule

// File: dv/tb_event_countdown_scheduler_top.sv
`timescale 1ns / 1ps
module tb_event_countdown_scheduler_top;
    import ecs_pkg::*;

    localparam int                 SLOTS        = SLOT_COUNT_DEF;
    localparam int                 SETTLE_CYCLES = 24;
    localparam int                 CYCLE_LIMIT  = 200000;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic [39:0] i_s_tdata   = '0;
    logic [1:0]  i_s_tuser   = '0;
    logic        i_m_tready  = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic        i_cfg_addr  = 1'b0;
    logic [30:0] i_cfg_wdata = '0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [39:0] o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        o_m_tlast;

    int fail_count;
    int results_owed;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int cycles        = 0;

    event_countdown_scheduler_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    event_countdown_checker u_results (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_tvalid     (i_s_tvalid),
        .i_s_tready     (o_s_tready),
        .i_s_tdata      (i_s_tdata),
        .i_s_tuser      (i_s_tuser),
        .i_m_tvalid     (o_m_tvalid),
        .i_m_tready     (i_m_tready),
        .i_m_tdata      (o_m_tdata),
        .i_m_tuser      (o_m_tuser),
        .i_m_tlast      (o_m_tlast),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_fail_count   (fail_count),
        .o_results_owed (results_owed)
    );

    // 100 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // offer one item after a random gap and hold it until taken
    task automatic send_item(t_func_e fn, logic [SLOT_W-1:0] sl, logic [COUNT_W-1:0] amt);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= fn;
        i_s_tdata  <= {6'd0, amt, sl};
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // stop sending and wait for every owed result, then let the block settle
    task automatic drain();
        int waited;
        waited = 0;
        i_s_tvalid <= 1'b0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (results_owed != 0 && waited < 20000);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // both registers, back to back, only while idle
    task automatic write_config(logic [SLOT_W-1:0] rs, logic [COUNT_W-1:0] period);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_RELOAD_SLOT;
        i_cfg_wdata <= COUNT_W'(rs);
        @(posedge i_clk);
        i_cfg_addr  <= CFG_RELOAD_PERIOD;
        i_cfg_wdata <= period;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // stimulus
    initial begin
        logic [SLOT_W-1:0]  phase_slot [6];
        logic [COUNT_W-1:0] phase_period [6];
        int                 pick;
        t_func_e            fn;
        logic [SLOT_W-1:0]  sl;
        logic [COUNT_W-1:0] amt;

        phase_slot   = '{3'd7, 3'd0, 3'd5, 3'd2, 3'd1, 3'd3};
        phase_period = '{COUNT_MAX, 31'd1, 31'd0, 31'd20, 31'd5, 31'h4000_0000};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table, then a zero count that fires on a zero advance
        send_item(FN_QUERY, 3'd0, COUNT_MAX);
        send_item(FN_QUERY, 3'd7, 31'd0);
        send_item(FN_ADVANCE, 3'd0, 31'd0);
        send_item(FN_ARM, 3'd0, 31'd0);
        send_item(FN_QUERY, 3'd0, 31'd100);
        send_item(FN_ADVANCE, 3'd0, 31'd0);

        // every slot at full count, out-of-range slots ignored, then all fire at once
        for (int s = 0; s < 8; s++)
            send_item(FN_ARM, SLOT_W'(s), COUNT_MAX);
        send_item(FN_ADVANCE, 3'd0, COUNT_MAX - 31'd1);
        send_item(FN_QUERY, 3'd0, COUNT_MAX);
        send_item(FN_ADVANCE, 3'd0, COUNT_MAX);

        // cancelled slot stays quiet, cancel out of range ignored
        send_item(FN_ARM, 3'd3, 31'd10);
        send_item(FN_CANCEL, 3'd3, 31'd0);
        send_item(FN_CANCEL, 3'd6, 31'd0);
        send_item(FN_ADVANCE, 3'd0, 31'd5);
        drain();

        // reload slot re-arms and is not decremented again in the same advance
        write_config(3'd1, 31'd3);
        send_item(FN_ARM, 3'd1, 31'd2);
        send_item(FN_ADVANCE, 3'd0, 31'd2);
        send_item(FN_QUERY, 3'd0, COUNT_MAX);
        send_item(FN_ADVANCE, 3'd0, 31'd3);
        drain();

        // random phases, each with its own register setting and one of four idling mixes
        for (int p = 0; p < 6; p++) begin
            write_config(phase_slot[p], phase_period[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 61; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 61; end
                default: begin send_idle_pct = 19; stall_pct = 19; end
            endcase
            for (int n = 0; n < 18; n++) begin
                pick = $urandom_range(0, 99);
                fn = (pick < 35) ? FN_ARM :
                     (pick < 45) ? FN_CANCEL :
                     (pick < 80) ? FN_ADVANCE : FN_QUERY;
                // mostly real slots, now and then one beyond the table
                if ($urandom_range(0, 9) == 0)
                    sl = SLOT_W'($urandom_range(SLOTS, 7));
                else
                    sl = SLOT_W'($urandom_range(0, SLOTS - 1));
                // short counts so slots actually fire, plus extremes and full range
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    amt = COUNT_W'($urandom_range(0, 40));
                else if (pick < 80)
                    amt = COUNT_MAX - COUNT_W'($urandom_range(0, 3));
                else
                    amt = COUNT_W'($urandom());
                send_item(fn, sl, amt);
            end
            drain();
        end

        if (fail_count == 0 && results_owed == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
